FILE: src/rrl_pkg.sv
// Shared constants and types for the relocation ring range lookup unit.
package rrl_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W     = 64;
  localparam int OBJ_SIZE_W = 48;
  localparam int SIZE_W     = 32;
  localparam int PST_W      = 32;
  localparam int SCAN_W     = 21;

  localparam logic [SIZE_W-1:0] SIZE_SAT   = 32'hffff_ffff;
  localparam logic [SCAN_W-1:0] SCAN_RESET = SCAN_W'(1 << 16);

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [SIZE_W-1:0] size;
    logic [PST_W-1:0]  pst;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic take;
    logic record;
    logic start;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    logic req_kind;
    logic scan_over;
    logic out_free;
  } status_t;

endpackage

FILE: src/rrl_req_if.sv
// Request channel: relocation records and address lookups.
interface rrl_req_if;
  import rrl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [ADDR_W-1:0]     from_addr;
  logic [ADDR_W-1:0]     to_addr;
  logic [OBJ_SIZE_W-1:0] obj_size;
  logic [PST_W-1:0]      prior_state;
  logic [ADDR_W-1:0]     query_addr;

  modport source (
    output valid, kind, from_addr, to_addr, obj_size, prior_state, query_addr,
    input  ready
  );
  modport sink (
    input  valid, kind, from_addr, to_addr, obj_size, prior_state, query_addr,
    output ready
  );
endinterface

FILE: src/rrl_rsp_if.sv
// Response channel: lookup results.
interface rrl_rsp_if;
  import rrl_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [ADDR_W-1:0] hit_from;
  logic [ADDR_W-1:0] hit_to;
  logic [SIZE_W-1:0] hit_size;
  logic [PST_W-1:0]  hit_prior_state;

  modport source (
    output valid, hit, hit_from, hit_to, hit_size, hit_prior_state,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_from, hit_to, hit_size, hit_prior_state,
    output ready
  );
endinterface

FILE: src/rrl_ram.sv
// Generic simple dual-port RAM with registered read.
module rrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rrl_ctrl.sv
// Controller state machine: accept, scan, deliver.
module rrl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  rrl_pkg::status_t status,
  output rrl_pkg::cmd_t    cmd
);
  import rrl_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (status.req_valid && status.req_kind == KIND_LOOKUP) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_over) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.take   = 1'b1;
        cmd.record = status.req_valid && status.req_kind == KIND_RECORD;
        cmd.start  = status.req_valid && status.req_kind == KIND_LOOKUP;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/rrl_datapath.sv
// Datapath: ring storage, write pointer, scan pointer, range compare, result register.
module rrl_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [rrl_pkg::SCAN_W-1:0] cfg_data,
  rrl_req_if.sink          req,
  rrl_rsp_if.source        rsp,
  input  rrl_pkg::cmd_t    cmd,
  output rrl_pkg::status_t status
);
  import rrl_pkg::*;

  logic [SCAN_W-1:0] scan_limit;
  logic [IDX_W-1:0]  write_index;
  logic [CNT_W-1:0]  fill_count;

  logic [ADDR_W-1:0] query;
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  remaining;
  logic              pending;
  logic              found;

  entry_t            best;
  logic              out_valid;
  logic              out_hit;
  entry_t            out_entry;

  entry_t            wr_entry;
  entry_t            rd_entry;
  logic              keep;
  logic              wr_en;
  logic              issue;
  logic              hit_now;
  logic [ADDR_W:0]   diff;
  logic [CNT_W-1:0]  scan_count;

  // Record filter and size saturation
  assign keep = req.from_addr != '0 && req.to_addr != '0 &&
                req.from_addr != req.to_addr && req.obj_size != '0;
  assign wr_en = cmd.record && keep;

  always_comb begin
    wr_entry.src  = req.from_addr;
    wr_entry.dst  = req.to_addr;
    wr_entry.size = (|req.obj_size[OBJ_SIZE_W-1:SIZE_W]) ? SIZE_SAT
                                                          : req.obj_size[SIZE_W-1:0];
    wr_entry.pst  = req.prior_state;
  end

  rrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (write_index),
    .wdata (wr_entry),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  // Number of entries one lookup may visit
  always_comb begin
    if (req.query_addr == '0) begin
      scan_count = '0;
    end else if (SCAN_W'(fill_count) < scan_limit) begin
      scan_count = fill_count;
    end else begin
      scan_count = CNT_W'(scan_limit);
    end
  end

  // Range check: query - base must borrow nothing and stay below size
  assign diff    = {1'b0, query} - {1'b0, rd_entry.src};
  assign hit_now = pending && !found && !diff[ADDR_W] &&
                   diff[ADDR_W-1:SIZE_W] == '0 && diff[SIZE_W-1:0] < rd_entry.size;
  assign issue   = cmd.scan && remaining != '0 && !found && !hit_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit  <= SCAN_RESET;
      write_index <= '0;
      fill_count  <= '0;
      remaining   <= '0;
      pending     <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        scan_limit <= cfg_data;
      end

      if (wr_en) begin
        write_index <= (write_index == IDX_W'(RING_DEPTH - 1)) ? '0 : write_index + 1'b1;
        if (fill_count != CNT_W'(RING_DEPTH)) begin
          fill_count <= fill_count + 1'b1;
        end
      end

      if (cmd.start) begin
        remaining <= scan_count;
        pending   <= 1'b0;
        found     <= 1'b0;
      end else begin
        pending <= issue;
        if (issue) begin
          remaining <= remaining - 1'b1;
        end
        if (hit_now) begin
          found <= 1'b1;
        end
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan pointer walks newest to oldest; payload registers need no reset
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      query  <= req.query_addr;
      rd_idx <= (write_index == '0) ? IDX_W'(RING_DEPTH - 1) : write_index - 1'b1;
      best   <= '0;
    end else begin
      if (issue) begin
        rd_idx <= (rd_idx == '0) ? IDX_W'(RING_DEPTH - 1) : rd_idx - 1'b1;
      end
      if (hit_now) begin
        best <= rd_entry;
      end
    end
    if (cmd.load_out) begin
      out_hit   <= found;
      out_entry <= best;
    end
  end

  assign req.ready           = cmd.take;
  assign rsp.valid           = out_valid;
  assign rsp.hit             = out_hit;
  assign rsp.hit_from        = out_entry.src;
  assign rsp.hit_to          = out_entry.dst;
  assign rsp.hit_size        = out_entry.size;
  assign rsp.hit_prior_state = out_entry.pst;

  assign status.req_valid = req.valid;
  assign status.req_kind  = req.kind;
  assign status.scan_over = found || (remaining == '0 && !pending);
  assign status.out_free  = !out_valid || rsp.ready;

endmodule

FILE: src/relocation_ring_range_lookup_unit.sv
// Top level of the relocation ring range lookup unit.
//
//   channel  dir  handshake      carries
//   req      in   valid/ready    kind, from_addr, to_addr, obj_size, prior_state, query_addr
//   rsp      out  valid/ready    hit, hit_from, hit_to, hit_size, hit_prior_state
//   cfg      in   cfg_we         cfg_data = scan_limit
//
// A record is written to the ring at acceptance and gets no response.
// A lookup visits at most min(fill, scan_limit) entries, the single ring read
// port visiting one entry per cycle; it stops early on a hit.
// Synchronous reset empties the ring at once (fill count cleared, no sweep).
// A pending response holds in the output register; records still go in,
// and a finished lookup waits in its done state until rsp is free.
module relocation_ring_range_lookup_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rrl_pkg::SCAN_W-1:0] cfg_data,
  rrl_req_if.sink                    req,
  rrl_rsp_if.source                  rsp
);
  import rrl_pkg::*;

  cmd_t    cmd;
  status_t status;

  rrl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rrl_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

FILE: tb/relocation_ring_range_lookup_unit_tb.sv
// Testbench for the relocation ring range lookup unit: directed and random requests, self-checked.
`timescale 1ns / 100ps

module relocation_ring_range_lookup_unit_tb;
  import rrl_pkg::*;

  localparam logic [SCAN_W-1:0] SCAN_MAX    = SCAN_W'(1 << 20);
  localparam logic [ADDR_W-1:0] REGION_BASE = 64'h0000_0000_1000_0000;
  localparam logic [ADDR_W-1:0] WRAP_BASE   = 64'h0000_0000_7000_0000;
  localparam logic [ADDR_W-1:0] WRAP_DST    = 64'h0000_0000_8000_0000;
  localparam int WRAP_PROBES [6] = '{0, 12, 13, 14, 600, 1029};
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = RING_DEPTH + 16;
  localparam int STALL_LIMIT   = 12000;

  typedef struct packed {
    logic                  kind;
    logic [ADDR_W-1:0]     from_addr;
    logic [ADDR_W-1:0]     to_addr;
    logic [OBJ_SIZE_W-1:0] obj_size;
    logic [PST_W-1:0]      prior_state;
    logic [ADDR_W-1:0]     query_addr;
  } reloc_req_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] hit_from;
    logic [ADDR_W-1:0] hit_to;
    logic [SIZE_W-1:0] hit_size;
    logic [PST_W-1:0]  hit_prior_state;
  } lookup_res_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [SCAN_W-1:0] cfg_data;

  rrl_req_if req_ch ();
  rrl_rsp_if rsp_ch ();

  relocation_ring_range_lookup_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always #2 clk = ~clk;

  // Shadow of the relocation ring and the scan window
  logic [ADDR_W-1:0] ring_src  [RING_DEPTH];
  logic [ADDR_W-1:0] ring_dst  [RING_DEPTH];
  logic [SIZE_W-1:0] ring_size [RING_DEPTH];
  logic [PST_W-1:0]  ring_pst  [RING_DEPTH];
  logic [IDX_W-1:0]  ring_wr   = '0;
  logic [CNT_W-1:0]  ring_fill = '0;
  logic [SCAN_W-1:0] scan_lim  = SCAN_RESET;

  lookup_res_t lookup_results_due [$];
  int          mismatches      = 0;
  int          quiet_cycles    = 0;
  int          rsp_hold_cycles = 0;
  bit          no_gaps         = 1'b0;
  reloc_req_t  seen_req;
  lookup_res_t due;
  logic        moved;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  function automatic void track_relocation(input reloc_req_t r);
    if (r.from_addr == '0 || r.to_addr == '0 || r.from_addr == r.to_addr ||
        r.obj_size == '0)
      return;
    ring_src[ring_wr]  = r.from_addr;
    ring_dst[ring_wr]  = r.to_addr;
    ring_size[ring_wr] = (r.obj_size > OBJ_SIZE_W'(SIZE_SAT)) ? SIZE_SAT
                                                               : r.obj_size[SIZE_W-1:0];
    ring_pst[ring_wr]  = r.prior_state;
    ring_wr = IDX_W'((int'(ring_wr) + 1) % RING_DEPTH);
    if (ring_fill < CNT_W'(RING_DEPTH))
      ring_fill++;
  endfunction

  function automatic lookup_res_t resolve_lookup(input logic [ADDR_W-1:0] addr);
    lookup_res_t      res;
    int               span;
    logic [IDX_W-1:0] slot;
    res  = '0;
    span = (int'(ring_fill) < int'(scan_lim)) ? int'(ring_fill) : int'(scan_lim);
    if (addr == '0)
      return res;
    // Walk newest to oldest; first containing range wins
    for (int i = 0; i < span && !res.hit; i++) begin
      slot = IDX_W'(int'(ring_wr) - 1 - i);
      if (addr >= ring_src[slot] && addr - ring_src[slot] < ADDR_W'(ring_size[slot])) begin
        res.hit             = 1'b1;
        res.hit_from        = ring_src[slot];
        res.hit_to          = ring_dst[slot];
        res.hit_size        = ring_size[slot];
        res.hit_prior_state = ring_pst[slot];
      end
    end
    return res;
  endfunction

  // Predict at request acceptance, check at response acceptance, watch for hangs
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (cfg_we)
        scan_lim = cfg_data;
      if (req_ch.valid && req_ch.ready) begin
        moved                = 1'b1;
        seen_req.kind        = req_ch.kind;
        seen_req.from_addr   = req_ch.from_addr;
        seen_req.to_addr     = req_ch.to_addr;
        seen_req.obj_size    = req_ch.obj_size;
        seen_req.prior_state = req_ch.prior_state;
        seen_req.query_addr  = req_ch.query_addr;
        if (seen_req.kind == KIND_LOOKUP)
          lookup_results_due.push_back(resolve_lookup(seen_req.query_addr));
        else
          track_relocation(seen_req);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        moved = 1'b1;
        if (lookup_results_due.size() == 0) begin
          flag_mismatch("result with no lookup pending", rsp_ch.hit_from, '0);
        end else begin
          due = lookup_results_due.pop_front();
          if (rsp_ch.hit !== due.hit)
            flag_mismatch("hit", 64'(rsp_ch.hit), 64'(due.hit));
          if (rsp_ch.hit_from !== due.hit_from)
            flag_mismatch("hit_from", rsp_ch.hit_from, due.hit_from);
          if (rsp_ch.hit_to !== due.hit_to)
            flag_mismatch("hit_to", rsp_ch.hit_to, due.hit_to);
          if (rsp_ch.hit_size !== due.hit_size)
            flag_mismatch("hit_size", 64'(rsp_ch.hit_size), 64'(due.hit_size));
          if (rsp_ch.hit_prior_state !== due.hit_prior_state)
            flag_mismatch("hit_prior_state", 64'(rsp_ch.hit_prior_state),
                          64'(due.hit_prior_state));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic bit take_break();
    return !no_gaps && ($urandom_range(99) < 37);
  endfunction

  // Response side: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (rsp_hold_cycles > 0) begin
      rsp_ch.ready = 1'b0;
      rsp_hold_cycles--;
    end else begin
      rsp_ch.ready = !take_break();
    end
  end

  task automatic send_request(input reloc_req_t r);
    @(negedge clk);
    while (take_break()) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.kind        = r.kind;
    req_ch.from_addr   = r.from_addr;
    req_ch.to_addr     = r.to_addr;
    req_ch.obj_size    = r.obj_size;
    req_ch.prior_state = r.prior_state;
    req_ch.query_addr  = r.query_addr;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
  endtask

  task automatic wait_lookups_done();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (lookup_results_due.size() != 0)
      @(negedge clk);
    // let a trailing record land before touching the register
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_scan_limit(input logic [SCAN_W-1:0] value);
    wait_lookups_done();
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  function automatic reloc_req_t noise_req();
    reloc_req_t r;
    r.kind        = 1'($urandom);
    r.from_addr   = {$urandom, $urandom};
    r.to_addr     = {$urandom, $urandom};
    r.obj_size    = OBJ_SIZE_W'({$urandom, $urandom});
    r.prior_state = $urandom;
    r.query_addr  = {$urandom, $urandom};
    return r;
  endfunction

  function automatic reloc_req_t record_req(input logic [ADDR_W-1:0] src,
                                            input logic [ADDR_W-1:0] dst,
                                            input logic [OBJ_SIZE_W-1:0] len,
                                            input logic [PST_W-1:0] pst);
    reloc_req_t r;
    r             = noise_req();
    r.kind        = KIND_RECORD;
    r.from_addr   = src;
    r.to_addr     = dst;
    r.obj_size    = len;
    r.prior_state = pst;
    return r;
  endfunction

  function automatic reloc_req_t lookup_req(input logic [ADDR_W-1:0] addr);
    reloc_req_t r;
    r            = noise_req();
    r.kind       = KIND_LOOKUP;
    r.query_addr = addr;
    return r;
  endfunction

  function automatic reloc_req_t draw_record();
    reloc_req_t r;
    int         pick;
    r      = noise_req();
    r.kind = KIND_RECORD;
    pick   = $urandom_range(99);
    // Mostly small ranges packed into one region so they overlap
    if (pick < 70) begin
      r.from_addr = REGION_BASE + (64'($urandom_range(4095)) << 4);
      r.obj_size  = OBJ_SIZE_W'($urandom_range(512, 1));
    end else if (pick < 76) begin
      r.obj_size = OBJ_SIZE_W'(64'h1_0000_0000 - 64'($urandom_range(2)));
    end else if (pick < 80) begin
      r.obj_size = OBJ_SIZE_W'($urandom_range(64, 1));
    end else if (pick < 83) begin
      r.from_addr = '0;
    end else if (pick < 86) begin
      r.to_addr = '0;
    end else if (pick < 89) begin
      r.to_addr = r.from_addr;
    end else if (pick < 92) begin
      r.obj_size = '0;
    end
    return r;
  endfunction

  function automatic reloc_req_t draw_lookup();
    reloc_req_t       r;
    int               pick;
    int               reach;
    int               age;
    logic [IDX_W-1:0] slot;
    r      = noise_req();
    r.kind = KIND_LOOKUP;
    pick   = $urandom_range(99);
    if (ring_fill != '0 && pick < 70) begin
      // Aim at a stored range, usually a recent one
      reach = (pick < 40 && int'(ring_fill) > 32) ? 32 : int'(ring_fill);
      age   = $urandom_range(reach - 1);
      slot  = IDX_W'(int'(ring_wr) - 1 - age);
      if (pick < 55)
        r.query_addr = ring_src[slot] + 64'($urandom_range(ring_size[slot] - 1));
      else if (pick < 63)
        r.query_addr = ring_src[slot] + 64'(ring_size[slot]);
      else
        r.query_addr = ring_src[slot] - 1;
    end else if (pick < 80) begin
      r.query_addr = '0;
    end else if (pick < 90) begin
      r.query_addr = REGION_BASE + 64'($urandom_range(20'hfffff));
    end
    return r;
  endfunction

  task automatic test_directed_edges();
    // empty ring
    send_request(lookup_req('1));
    send_request(lookup_req('0));
    // dropped records
    send_request(record_req('0, 64'h9000, 48'h10, 32'h1));
    send_request(record_req(64'h1000, '0, 48'h10, 32'h1));
    send_request(record_req(64'h1000, 64'h1000, 48'h10, 32'h1));
    send_request(record_req(64'h1000, 64'h9000, '0, 32'h1));
    send_request(lookup_req(64'h1000));
    // top of the address space with the widest size
    send_request(record_req(64'hffff_ffff_ffff_fff0, '1, '1, '1));
    send_request(lookup_req('1));
    // overlapping ranges: newest wins
    send_request(record_req(64'h1000, 64'h9000, 48'h100, 32'h11));
    send_request(record_req(64'h1080, 64'ha000, 48'h40, 32'h22));
    send_request(lookup_req(64'h1090));
    send_request(lookup_req(64'h10ff));
    send_request(lookup_req(64'h1100));
    send_request(lookup_req(64'h0fff));
    send_request(lookup_req(64'h1000));
    // sizes at and above the 32-bit limit
    send_request(record_req(64'h2000_0000, 64'h1, 48'hffff_ffff, '0));
    send_request(record_req(64'h4_0000_0000, 64'h2, 48'h1_0000_0000, 32'h5a5a));
    send_request(lookup_req(64'h2000_0000 + 64'hffff_fffe));
    send_request(lookup_req(64'h2000_0000 + 64'hffff_ffff));
    send_request(lookup_req(64'h4_ffff_fffe));
    send_request(lookup_req(64'h4_ffff_ffff));
    send_request(lookup_req('0));
  endtask

  task automatic test_scan_limit_edges();
    set_scan_limit(SCAN_W'(1));
    send_request(record_req(64'h3000, 64'h3_3000, 48'h100, 32'h0a));
    send_request(record_req(64'h5000, 64'h5_5000, 48'h10, 32'h0b));
    send_request(lookup_req(64'h3010));
    send_request(lookup_req(64'h5008));
    set_scan_limit(SCAN_W'(2));
    send_request(lookup_req(64'h3010));
    send_request(lookup_req(64'h1010));
    set_scan_limit('0);
    send_request(lookup_req(64'h5008));
    set_scan_limit(SCAN_MAX);
    send_request(lookup_req(64'h1010));
    send_request(lookup_req('1));
  endtask

  task automatic probe_wrap();
    foreach (WRAP_PROBES[k])
      send_request(lookup_req(WRAP_BASE + 64'(WRAP_PROBES[k]) * 'h100 + 'h7f));
  endtask

  task automatic test_ring_wrap();
    no_gaps = 1'b1;
    for (int i = 0; i < RING_DEPTH + 6; i++)
      send_request(record_req(WRAP_BASE + 64'(i) * 'h100, WRAP_DST + 64'(i) * 'h100,
                              48'h80, PST_W'(i)));
    probe_wrap();
    set_scan_limit(SCAN_W'(RING_DEPTH - 1));
    probe_wrap();
    set_scan_limit(SCAN_W'(RING_DEPTH));
    probe_wrap();
    no_gaps = 1'b0;
  endtask

  task automatic test_output_backpressure();
    @(negedge clk);
    // long enough for two full-ring scans to finish behind the held response
    rsp_hold_cycles = 3 * RING_DEPTH;
    // keep offering while responses are held back
    repeat (6) begin
      send_request(draw_lookup());
      repeat (3) send_request(draw_record());
    end
    wait_lookups_done();
  endtask

  task automatic test_random_traffic();
    logic [SCAN_W-1:0] limits [3];
    limits[0] = SCAN_W'($urandom_range(48, 1));
    limits[1] = SCAN_W'(RING_DEPTH);
    limits[2] = SCAN_MAX;
    foreach (limits[p]) begin
      set_scan_limit(limits[p]);
      repeat (135)
        send_request(($urandom_range(99) < 15) ? draw_lookup() : draw_record());
    end
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_RECORD;
    req_ch.from_addr   = '0;
    req_ch.to_addr     = '0;
    req_ch.obj_size    = '0;
    req_ch.prior_state = '0;
    req_ch.query_addr  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_edges();
    test_scan_limit_edges();
    test_ring_wrap();
    test_output_backpressure();
    test_random_traffic();

    wait_lookups_done();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (lookup_results_due.size() != 0)
      flag_mismatch("lookups left unanswered", 64'(lookup_results_due.size()), '0);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
